// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/is_pkg.sv =====
`timescale 1ns / 1ps

package is_pkg;

  localparam int VAL_W     = 32;
  localparam int POS_W     = 4;
  localparam int OUT_LIMIT = 16;
  localparam int RUN_W     = 5;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [RUN_W-1:0]        run_t;

  // controller to datapath
  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    run_t run_len;
    logic ovf;
  } status_t;

endpackage

// ===== rtl/is_in_if.sv =====
`timescale 1ns / 1ps

interface is_in_if import is_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   end_of_set;

  modport source (output valid, output value, output end_of_set, input ready);
  modport sink (input valid, input value, input end_of_set, output ready);
endinterface

// ===== rtl/is_out_if.sv =====
`timescale 1ns / 1ps

interface is_out_if import is_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t sorted_value;
  pos_t   position;
  logic   last_of_run;
  logic   overflow;

  modport source (
    output valid, output sorted_value, output position, output last_of_run,
    output overflow, input ready
  );
  modport sink (
    input valid, input sorted_value, input position, input last_of_run,
    input overflow, output ready
  );
endinterface

// ===== rtl/is_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module is_ctrl import is_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_end,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output pos_t    position,
  output logic    out_last,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [0:0] {
    S_LOAD,
    S_EMIT
  } state_t;

  state_t state;
  run_t   idx;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_EMIT);
  assign out_last  = ((idx + run_t'(1)) == status.run_len);
  assign position  = idx[POS_W-1:0];

  assign cmd.insert = in_valid && in_ready;
  assign cmd.shift  = out_valid && out_ready;
  assign cmd.clear  = cmd.shift && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      idx   <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          idx <= '0;
          if (in_valid && in_end) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (out_last) begin
              state <= S_LOAD;
            end else begin
              idx <= idx + run_t'(1);
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `AST_IMPL(a_excl, 1'b1, !(in_ready && out_valid), "input and output open together")
  `AST_NEXT(a_emit, in_valid && in_ready && in_end, out_valid, "run not emitted after end")
  `AST_NEXT(a_pos, out_valid && out_ready && !out_last, position == $past(position) + pos_t'(1),
            "position did not advance")

endmodule

// ===== rtl/is_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module is_dp import is_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  value_t  value,
  output value_t  head,
  output status_t status
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  value_t             cells      [DEPTH];
  value_t             cells_next [DEPTH];
  logic [DEPTH-1:0]   gt;
  logic [CNT_W-1:0]   count;
  logic               dropped;
  logic               full;
  logic               over_limit;

  assign full       = (count == CNT_W'(DEPTH));
  assign over_limit = (int'(count) > OUT_LIMIT);
  assign head       = cells[0];

  assign status.run_len = over_limit ? run_t'(OUT_LIMIT) : run_t'(count);
  assign status.ovf     = dropped || over_limit;

  // Each cell compares against the new value; the row is sorted, so gt is a
  // thermometer and the value lands at the first cell that is greater.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign gt[i] = (CNT_W'(i) < count) && (cells[i] > value);
    if (i == 0) begin : g_first
      assign cells_next[i] = (gt[i] || (count == '0)) ? value : cells[i];
    end else begin : g_rest
      logic prev_gt;
      assign prev_gt = gt[i-1];
      assign cells_next[i] = prev_gt ? cells[i-1] :
                             ((gt[i] || (CNT_W'(i) == count)) ? value : cells[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && !full) begin
      cells <= cells_next;
    end else if (cmd.shift) begin
      // advance the run toward the head, one beat at a time
      for (int j = 0; j < DEPTH - 1; j++) begin
        cells[j] <= cells[j+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.clear) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.insert) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
      end
    end
  end

  `AST_IMPL(a_cnt, 1'b1, count <= CNT_W'(DEPTH), "entry count beyond depth")
  `AST_NEXT(a_drop, cmd.insert && full && !cmd.clear, dropped, "drop not flagged")
  `AST_NEXT(a_clr, cmd.clear, count == '0, "count not cleared after run")

endmodule

// ===== rtl/insertion_sorter.sv =====
`timescale 1ns / 1ps
// Insertion sorter: a row of DEPTH compare-and-shift cells.
// Load: one value accepted per cycle and placed in the row as it is taken.
// After an end-marked value, the first result appears on the next cycle and
// the run streams out at one beat per cycle while the receiver is ready,
// n beats for n entries (max 16). Input is held off while a run is emitted.
// Reset clears count, drop flag and control state, not the cell row.

module insertion_sorter import is_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic           clk,
  input logic           rst,
  is_in_if.sink         in_ch,
  is_out_if.source      out_ch
);

  cmd_t    cmd;
  status_t status;
  value_t  head;

  is_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_end    (in_ch.end_of_set),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .position  (out_ch.position),
    .out_last  (out_ch.last_of_run),
    .status    (status),
    .cmd       (cmd)
  );

  is_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .value  (in_ch.value),
    .head   (head),
    .status (status)
  );

  assign out_ch.sorted_value = head;
  assign out_ch.overflow     = status.ovf;

endmodule

// ===== tb/insertion_sorter_tb.sv =====
`timescale 1ns / 1ps

module insertion_sorter_tb;
  import is_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_LOADS = 380;

  typedef struct {
    value_t value;
    logic   eos;
    bit     wait_drain;
  } load_beat_t;

  typedef struct {
    value_t value;
    pos_t   pos;
    logic   last;
    logic   ovf;
  } sorted_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  is_in_if  in_ch ();
  is_out_if out_ch ();

  insertion_sorter #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // own copy of the sorted set being built
  value_t held [DEPTH];
  int     held_count = 0;
  logic   dropped = 1'b0;

  load_beat_t   load_queue [$];
  sorted_beat_t sorted_expect [$];
  int           load_total = 0;
  int           mismatches = 0;

  // Insert a value; on an end mark, queue the sorted run and start a new set.
  task automatic take_value(value_t v, logic eos);
    int slot;
    int run_len;
    logic run_ovf;
    sorted_beat_t beat;
    if (held_count >= DEPTH) begin
      dropped = 1'b1;
    end else begin
      slot = held_count;
      while (slot > 0 && held[slot-1] > v) begin
        held[slot] = held[slot-1];
        slot--;
      end
      held[slot] = v;
      held_count++;
    end
    if (eos) begin
      run_len = (held_count > OUT_LIMIT) ? OUT_LIMIT : held_count;
      run_ovf = dropped || (held_count > OUT_LIMIT);
      for (int k = 0; k < run_len; k++) begin
        beat.value = held[k];
        beat.pos   = pos_t'(k);
        beat.last  = (k + 1 == run_len);
        beat.ovf   = run_ovf;
        sorted_expect.push_back(beat);
      end
      held_count = 0;
      dropped    = 1'b0;
    end
  endtask

  task automatic add_load(value_t v, logic eos, bit wait_drain);
    load_beat_t b;
    b.value      = v;
    b.eos        = eos;
    b.wait_drain = wait_drain;
    load_queue.push_back(b);
    load_total++;
  endtask

  function automatic value_t pick_value(int flavour);
    case (flavour)
      0: return value_t'($urandom);
      // narrow range: plenty of equal values
      1: return value_t'(int'($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0;
          3: return -32'sh1;
          default: return 32'sh1;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 1) return value_t'($urandom);
        return value_t'(int'($urandom_range(0, 200)) - 100);
      end
    endcase
  endfunction

  // sender: bursts of beats with random gaps
  int         burst_left = 0;
  int         gap_left = 0;
  bit         load_taken;
  load_beat_t next_load;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      load_taken = in_ch.valid && in_ch.ready;
      if (load_taken) take_value(in_ch.value, in_ch.end_of_set);
      if (in_ch.valid && !load_taken) begin
        // hold the beat until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (load_queue.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (load_queue[0].wait_drain && sorted_expect.size() != 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        next_load = load_queue.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.value      <= next_load.value;
        in_ch.end_of_set <= next_load.eos;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: ready follows one of four stall patterns, each picked for a random span
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(8, 60);
      end
      mode_left--;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        2: out_ch.ready <= ($urandom_range(0, 7) != 0);
        default: begin
          if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) hold_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  sorted_beat_t want_beat;

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (sorted_expect.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual value %h pos %0d",
                 $time, out_ch.sorted_value, out_ch.position);
        mismatches++;
      end else begin
        want_beat = sorted_expect.pop_front();
        check_field("sorted_value", want_beat.value, out_ch.sorted_value);
        check_field("position", 32'(want_beat.pos), 32'(out_ch.position));
        check_field("last_of_run", 32'(want_beat.last), 32'(out_ch.last_of_run));
        check_field("overflow", 32'(want_beat.ovf), 32'(out_ch.overflow));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("insertion_sorter regression: fail");
    $finish;
  end

  int set_len;
  int flavour;
  int set_no;

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.value      = '0;
    in_ch.end_of_set = 1'b0;
    out_ch.ready     = 1'b0;

    // single entry run at the lowest value
    add_load(32'sh8000_0000, 1'b1, 1'b0);
    // extremes with equal values
    add_load(32'sh7fff_ffff, 1'b0, 1'b0);
    add_load(32'sh8000_0000, 1'b0, 1'b0);
    add_load(32'sh0, 1'b0, 1'b0);
    add_load(-32'sh1, 1'b0, 1'b0);
    add_load(32'sh0, 1'b1, 1'b0);
    // fill in descending order, then drop the end-marked value
    for (int k = 0; k < DEPTH; k++)
      add_load(value_t'((DEPTH - 1 - k) * 1000 - 8000), 1'b0, 1'b0);
    add_load(32'sh8000_0000, 1'b1, 1'b0);

    set_no = 0;
    while (load_total < RANDOM_LOADS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: set_len = $urandom_range(1, 8);
        6, 7:             set_len = $urandom_range(9, 15);
        8:                set_len = DEPTH;
        default:          set_len = $urandom_range(DEPTH + 1, DEPTH + 6);
      endcase
      flavour = $urandom_range(0, 3);
      for (int k = 0; k < set_len; k++)
        add_load(pick_value(flavour), k == set_len - 1, (set_no % 12 == 0) && k == 0);
      set_no++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (load_queue.size() != 0 || in_ch.valid || sorted_expect.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && sorted_expect.size() == 0) begin
      $display("insertion_sorter regression: pass");
    end else begin
      $display("insertion_sorter regression: fail");
    end
    $finish;
  end

endmodule

// ===== insertion_sorter.f =====
+incdir+rtl
rtl/is_pkg.sv
rtl/is_in_if.sv
rtl/is_out_if.sv
rtl/is_ctrl.sv
rtl/is_dp.sv
rtl/insertion_sorter.sv
tb/insertion_sorter_tb.sv
